// ===== hdl/plp_pkg.sv =====
// Shared types and constants of the positional handle list.
`default_nettype none
package plp_pkg;

	localparam int unsigned POS_W     = 7;
	localparam int unsigned H_W       = 16;
	localparam int unsigned FIDX_W    = 6;
	localparam int unsigned CNT_OUT_W = 7;
	localparam int unsigned GRP_SIZE  = 32;
	localparam int unsigned GRP_BITS  = 5;

	typedef enum logic [2:0] {
		MODE_INSERT = 3'd0,
		MODE_REMOVE = 3'd1,
		MODE_GET    = 3'd2,
		MODE_FIND   = 3'd3,
		MODE_CLEAR  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_FLAG,
		ST_GROUP,
		ST_FINAL
	} state_t;

	// Latched transaction.
	typedef struct packed {
		logic [2:0]       mode;
		logic [POS_W-1:0] pos;
		logic [H_W-1:0]   handle;
		logic             ok;
	} op_t;

	// Control broadcast to every cell.
	typedef struct packed {
		logic             apply;
		logic             ins;
		logic             rem;
		logic             clr;
		logic             flag;
		logic [POS_W-1:0] pos;
		logic [H_W-1:0]   handle;
	} cell_ctrl_t;

	// Registered reduction of one group of cells.
	typedef struct packed {
		logic                hit;
		logic [GRP_BITS-1:0] first;
		logic                nz;
		logic [H_W-1:0]      pick;
	} grp_res_t;

endpackage
`default_nettype wire

// ===== hdl/plp_req_if.sv =====
// Request channel: operation, position and handle.
`default_nettype none
interface plp_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [6:0]  position;
	logic [15:0] handle;

	modport source (output valid, output mode, output position, output handle, input ready);
	modport sink (input valid, input mode, input position, input handle, output ready);
endinterface
`default_nettype wire

// ===== hdl/plp_rsp_if.sv =====
// Response channel: status, returned handle, search result and list flags.
`default_nettype none
interface plp_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [15:0] handle_out;
	logic        found;
	logic [5:0]  found_index;
	logic [6:0]  count;
	logic        all_empty;
	logic        full_res;

	modport source (output valid, output ok, output handle_out, output found,
		output found_index, output count, output all_empty, output full_res, input ready);
	modport sink (input valid, input ok, input handle_out, input found,
		input found_index, input count, input all_empty, input full_res, output ready);
endinterface
`default_nettype wire

// ===== hdl/positional_list_with_shift_insert.sv =====
// Top level of the positional handle list with shift-insert.
// Usage:
//   req carries one operation per transaction: mode (insert, remove, get,
//   find, clear), position and handle. rsp returns one transaction per
//   request with ok, the handle read by remove or get, the find result,
//   and the count, all-empty and full flags after the operation.
// Timing:
//   A request is taken only when the block is idle. Each request passes
//   through accept, apply to the cell chain (all later entries shift by
//   one together on insert), per-cell flag capture, a registered reduction
//   over groups of 32 cells, and the final priority select over the groups
//   into the response register. The next request is taken once the result
//   has been loaded into the response register.
// Reset:
//   arst_n clears every entry to empty, the count to zero, and drops any
//   pending response.
// Backpressure:
//   If rsp stalls, the finished result waits in the final stage until the
//   response register is free; requests are held off until then.
`default_nettype none
module positional_list_with_shift_insert #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	plp_req_if.sink  req,
	plp_rsp_if.source rsp
);
	import plp_pkg::*;

	localparam int unsigned CW    = $clog2(CAPACITY + 1);
	localparam int unsigned PW    = (CW > POS_W) ? CW : POS_W;
	localparam int unsigned OW    = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
	localparam int unsigned G     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
	localparam int unsigned LANES = G * GRP_SIZE;
	localparam int unsigned GIW   = (G > 1) ? $clog2(G) : 1;
	localparam int unsigned FW    = GIW + GRP_BITS;

	state_t         state_q;
	state_t         state_d;
	op_t            op_q;
	op_t            op_d;
	logic [CW-1:0]  count_q;
	cell_ctrl_t     ctrl;

	logic [CAPACITY-1:0][H_W-1:0] entry_all;
	logic [LANES-1:0]             match_all;
	logic [LANES-1:0]             nz_all;
	logic [LANES-1:0][H_W-1:0]    pick_all;
	grp_res_t                     grp [G];

	logic                 rsp_valid_q;
	logic                 ok_q;
	logic [H_W-1:0]       hout_q;
	logic                 found_q;
	logic [FIDX_W-1:0]    fidx_q;
	logic [CNT_OUT_W-1:0] cnt_out_q;
	logic                 empty_q;
	logic                 full_q;

	logic           accept;
	logic           load;
	logic [PW-1:0]  pos_x;
	logic [PW-1:0]  cnt_x;
	logic [OW-1:0]  cnt_o;
	logic           is_ins;
	logic           is_rem;
	logic           is_get;
	logic           is_find;
	logic           is_clr;
	logic           f_hit;
	logic [FW-1:0]  f_idx;
	logic           f_nz;
	logic [H_W-1:0] f_pick;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign pos_x     = PW'(req.position);
	assign cnt_x     = PW'(count_q);
	assign cnt_o     = OW'(count_q);

	// Decide validity at acceptance against the current count.
	always_comb begin
		op_d        = '0;
		op_d.mode   = req.mode;
		op_d.pos    = req.position;
		op_d.handle = req.handle;
		unique case (mode_t'(req.mode)) inside
			MODE_INSERT:
				op_d.ok = (pos_x <= cnt_x) && (count_q != CW'(CAPACITY));
			MODE_REMOVE, MODE_GET:
				op_d.ok = (pos_x < cnt_x);
			MODE_FIND, MODE_CLEAR:
				op_d.ok = 1'b1;
			default:
				op_d.ok = 1'b0;
		endcase
	end

	always_comb begin
		is_ins  = (op_q.mode == MODE_INSERT);
		is_rem  = (op_q.mode == MODE_REMOVE);
		is_get  = (op_q.mode == MODE_GET);
		is_find = (op_q.mode == MODE_FIND);
		is_clr  = (op_q.mode == MODE_CLEAR);
	end

	// Broadcast the latched operation to the cell chain.
	always_comb begin
		ctrl        = '0;
		ctrl.apply  = (state_q == ST_APPLY);
		ctrl.flag   = (state_q == ST_FLAG);
		ctrl.ins    = op_q.ok && is_ins;
		ctrl.rem    = op_q.ok && is_rem;
		ctrl.clr    = op_q.ok && is_clr;
		ctrl.pos    = op_q.pos;
		ctrl.handle = op_q.handle;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.apply && ctrl.ins) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Cell chain; each cell takes its left neighbor on a shift.
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [H_W-1:0] left;
			if (gi == 0) begin : g_head
				assign left = '0;
			end else begin : g_link
				assign left = entry_all[gi-1];
			end
			plp_cell #(
				.IDX (gi),
				.CW  (CW)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (ctrl),
				.count  (count_q),
				.left   (left),
				.entry  (entry_all[gi]),
				.match  (match_all[gi]),
				.nz     (nz_all[gi]),
				.pick   (pick_all[gi])
			);
		end
		for (gi = CAPACITY; gi < LANES; gi++) begin : g_pad
			assign match_all[gi] = 1'b0;
			assign nz_all[gi]    = 1'b0;
			assign pick_all[gi]  = '0;
		end
		for (gi = 0; gi < G; gi++) begin : g_grp
			plp_grp u_grp (
				.clk   (clk),
				.en    (state_q == ST_GROUP),
				.match (match_all[gi*GRP_SIZE +: GRP_SIZE]),
				.nz    (nz_all[gi*GRP_SIZE +: GRP_SIZE]),
				.pick  (pick_all[gi*GRP_SIZE +: GRP_SIZE]),
				.res   (grp[gi])
			);
		end
	endgenerate

	// Final select over the groups: lowest group with a hit wins.
	always_comb begin
		f_hit  = 1'b0;
		f_idx  = '0;
		f_nz   = 1'b0;
		f_pick = '0;
		for (int g = G - 1; g >= 0; g--) begin
			if (grp[g].hit) begin
				f_hit = 1'b1;
				f_idx = {GIW'(g), grp[g].first};
			end
			f_nz   = f_nz | grp[g].nz;
			f_pick = f_pick | grp[g].pick;
		end
	end

	assign load = (state_q == ST_FINAL) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_APPLY;
			ST_APPLY: state_d = ST_FLAG;
			ST_FLAG:  state_d = ST_GROUP;
			ST_GROUP: state_d = ST_FINAL;
			ST_FINAL: if (load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Response register: hold while stalled, drop on handoff.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ok_q      <= op_q.ok;
			hout_q    <= (op_q.ok && (is_rem || is_get)) ? f_pick : '0;
			found_q   <= is_find && f_hit;
			fidx_q    <= (is_find && f_hit) ? f_idx[FIDX_W-1:0] : '0;
			cnt_out_q <= cnt_o[CNT_OUT_W-1:0];
			empty_q   <= !f_nz;
			full_q    <= (count_q == CW'(CAPACITY));
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = ok_q;
	assign rsp.handle_out  = hout_q;
	assign rsp.found       = found_q;
	assign rsp.found_index = fidx_q;
	assign rsp.count       = cnt_out_q;
	assign rsp.all_empty   = empty_q;
	assign rsp.full_res    = full_q;

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count exceeds capacity");

	// The count moves only on an applied insert.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.apply && ctrl.ins) |=> $stable(count_q))
		else $error("count changed without insert");

	// An accepted request goes straight into the apply cycle.
	a_accept_apply: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_APPLY)
		else $error("accepted request not applied");

	// A find hit is always reported with ok.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && found_q |-> ok_q)
		else $error("found without ok");

endmodule
`default_nettype wire

// ===== hdl/plp_cell.sv =====
// One list cell: holds an entry, shifts from its left neighbor, flags itself.
`default_nettype none
module plp_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  plp_pkg::cell_ctrl_t         ctrl,
	input  logic [CW-1:0]               count,
	input  logic [plp_pkg::H_W-1:0]     left,
	output logic [plp_pkg::H_W-1:0]     entry,
	output logic                        match,
	output logic                        nz,
	output logic [plp_pkg::H_W-1:0]     pick
);
	import plp_pkg::*;

	localparam bit IN_RANGE = (IDX < (1 << POS_W));

	logic [H_W-1:0] entry_q;
	logic [H_W-1:0] pick_q;
	logic           match_q;
	logic           nz_q;
	logic           at_pos;
	logic           beyond;
	logic           used;

	always_comb begin
		at_pos = 1'b0;
		beyond = 1'b1;
		if (IN_RANGE) begin
			at_pos = (ctrl.pos == POS_W'(IDX));
			beyond = (POS_W'(IDX) > ctrl.pos);
		end
		used = (CW'(IDX) < count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctrl.apply) begin
			if (ctrl.clr) begin
				entry_q <= '0;
			end else if (ctrl.ins && at_pos) begin
				entry_q <= ctrl.handle;
			end else if (ctrl.ins && beyond) begin
				entry_q <= left;
			end else if (ctrl.rem && at_pos) begin
				entry_q <= '0;
			end
		end
	end

	// Capture the addressed entry before it is modified; set the match and nonzero flags in the flag step.
	always_ff @(posedge clk) begin
		if (ctrl.apply) begin
			pick_q <= at_pos ? entry_q : '0;
		end
		if (ctrl.flag) begin
			match_q <= used && (entry_q == ctrl.handle);
			nz_q    <= used && (entry_q != '0);
		end
	end

	assign entry = entry_q;
	assign pick  = pick_q;
	assign match = match_q;
	assign nz    = nz_q;

endmodule
`default_nettype wire

// ===== hdl/plp_grp.sv =====
// Registered reduction over one group of cells: first match, nonzero, pick.
`default_nettype none
module plp_grp (
	input  logic                                           clk,
	input  logic                                           en,
	input  logic [plp_pkg::GRP_SIZE-1:0]                   match,
	input  logic [plp_pkg::GRP_SIZE-1:0]                   nz,
	input  logic [plp_pkg::GRP_SIZE-1:0][plp_pkg::H_W-1:0] pick,
	output plp_pkg::grp_res_t                              res
);
	import plp_pkg::*;

	grp_res_t res_d;
	grp_res_t res_q;

	always_comb begin
		res_d       = '0;
		res_d.nz    = |nz;
		res_d.hit   = |match;
		for (int i = GRP_SIZE - 1; i >= 0; i--) begin
			if (match[i]) begin
				res_d.first = GRP_BITS'(i);
			end
			res_d.pick = res_d.pick | pick[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire
